@@ rtl/mcd_pkg.sv @@
`default_nettype none
package mcd_pkg;

  localparam int MaxHeight = 4096;
  localparam int RowBits = 12;
  localparam int HeightBits = 13;
  localparam int WidthBits = 15;
  localparam int LevelBits = 4;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_LEVELS = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_MERGE
  } state_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  typedef struct packed {
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
    logic [8:0] a;
  } psum_t;

  // Saturated configuration as the level sequencer sees it.
  typedef struct packed {
    logic [WidthBits-1:0]  width;
    logic [HeightBits-1:0] height;
    logic [LevelBits-1:0]  levels;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/mcd_pix_if.sv @@
`default_nettype none
interface mcd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface
`default_nettype wire

@@ rtl/mcd_res_if.sv @@
`default_nettype none
interface mcd_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  level;
  logic [10:0] column;
  logic [10:0] row;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        last;

  modport source (output valid, level, column, row, out_red, out_green, out_blue,
                  out_alpha, last, input ready);
  modport sink (input valid, level, column, row, out_red, out_green, out_blue,
                out_alpha, last, output ready);
endinterface
`default_nettype wire

@@ rtl/mcd_ram.sv @@
`default_nettype none
module mcd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/mcd_front.sv @@
`default_nettype none
module mcd_front import mcd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mcd_pix_if.sink     pix_i,
  input  wire logic   pop_i,
  output      logic   valid_o,
  output      pixel_t data_o
);

  pixel_t     buf_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;

  assign pix_i.ready = (count_q != 2'd2);
  assign push = pix_i.valid && pix_i.ready;
  assign valid_o = (count_q != 2'd0);
  assign pop = pop_i && valid_o;
  assign data_o = buf_q[rd_q];

  always_comb begin
    wr_d = push ? ~wr_q : wr_q;
    rd_d = pop ? ~rd_q : rd_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= '{r: pix_i.red, g: pix_i.green, b: pix_i.blue, a: pix_i.alpha};
    end
  end

endmodule
`default_nettype wire

@@ rtl/mcd_back.sv @@
`default_nettype none
module mcd_back import mcd_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_LEVELS = 13
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cfg_t   cfg_i,
  input  wire logic   clear_i,
  input  wire logic   in_valid_i,
  input  wire pixel_t in_data_i,
  output      logic   pop_o,
  mcd_res_if.source   res_o
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int LI = $clog2(MAX_LEVELS);
  localparam int AW = $clog2(MAX_WIDTH);

  state_e               state_q, state_d;
  logic [XW-1:0]        col_q [MAX_LEVELS];
  logic [RowBits-1:0]   row_q [MAX_LEVELS];
  pixel_t               held_q [MAX_LEVELS];
  logic [LI-1:0]        lv_q;
  pixel_t               pix_q;
  psum_t                sum_q;
  logic                 pend_q;
  logic [3:0]           pend_lv_q;
  logic [10:0]          pend_col_q;
  logic [10:0]          pend_row_q;

  logic                 ovalid_q;
  logic [3:0]           olv_q;
  logic [10:0]          ocol_q;
  logic [10:0]          orow_q;
  pixel_t               opix_q;
  logic                 olast_q;

  logic [XW-1:0]        x;
  logic [RowBits-1:0]   y;
  logic [WidthBits-1:0] wl, wn;
  logic [HeightBits-1:0] hl, hn;
  logic [3:0]           k;
  logic                 lv_ok, nxt_ok, go, hold_wr, row_wr;
  logic                 out_free, can, load_out, upd_cnt;
  psum_t                psum, rdata;
  logic [31:0]          idx_full;
  logic [AW-1:0]        idx;
  pixel_t               avg;

  always_comb begin
    x = col_q[lv_q];
    y = row_q[lv_q];
    k = 4'(lv_q) + 4'd1;
    wl = cfg_i.width >> lv_q;
    hl = cfg_i.height >> lv_q;
    wn = cfg_i.width >> k;
    hn = cfg_i.height >> k;
    lv_ok = (4'(lv_q) < cfg_i.levels) && (wl != '0) && (hl != '0);
    nxt_ok = (k < cfg_i.levels) && (wn != '0) && (hn != '0)
             && ({1'b0, WidthBits'(x)} < {wn, 1'b0})
             && ({1'b0, HeightBits'(y)} < {hn, 1'b0});
    go = lv_ok && nxt_ok && x[0] && y[0];
    hold_wr = lv_ok && nxt_ok && !x[0];
    row_wr = lv_ok && nxt_ok && x[0] && !y[0];
    psum.r = {1'b0, held_q[lv_q].r} + {1'b0, pix_q.r};
    psum.g = {1'b0, held_q[lv_q].g} + {1'b0, pix_q.g};
    psum.b = {1'b0, held_q[lv_q].b} + {1'b0, pix_q.b};
    psum.a = {1'b0, held_q[lv_q].a} + {1'b0, pix_q.a};
    idx_full = 32'(MAX_WIDTH) - (32'(MAX_WIDTH) >> lv_q) + 32'(x >> 1);
    idx = idx_full[AW-1:0];
    avg.r = 8'((10'(rdata.r) + 10'(sum_q.r) + 10'd2) >> 2);
    avg.g = 8'((10'(rdata.g) + 10'(sum_q.g) + 10'd2) >> 2);
    avg.b = 8'((10'(rdata.b) + 10'(sum_q.b) + 10'd2) >> 2);
    avg.a = 8'((10'(rdata.a) + 10'(sum_q.a) + 10'd2) >> 2);
  end

  assign out_free = !ovalid_q || res_o.ready;
  assign can = !pend_q || out_free;

  mcd_ram #(
    .WIDTH ($bits(psum_t)),
    .DEPTH (MAX_WIDTH)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (state_q == S_EVAL && can && row_wr),
    .waddr_i (idx),
    .wdata_i (psum),
    .raddr_i (idx),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (can) begin
          if (go) begin
            state_d = S_MERGE;
          end else if (!in_valid_i) begin
            state_d = S_IDLE;
          end
        end
      end
      S_MERGE: state_d = S_EVAL;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    load_out = 1'b0;
    upd_cnt = 1'b0;
    case (state_q)
      S_IDLE: pop_o = in_valid_i;
      S_EVAL: begin
        if (can) begin
          load_out = pend_q;
          upd_cnt = lv_ok;
          pop_o = !go && in_valid_i;
        end
      end
      S_MERGE: pop_o = 1'b0;
      default: pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q <= 1'b0;
      ovalid_q <= 1'b0;
      lv_q <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (load_out) begin
        ovalid_q <= 1'b1;
      end else if (res_o.ready) begin
        ovalid_q <= 1'b0;
      end
      if (pop_o) begin
        lv_q <= '0;
        pend_q <= 1'b0;
      end else if (state_q == S_MERGE) begin
        lv_q <= lv_q + LI'(1);
        pend_q <= 1'b1;
      end else if (state_q == S_EVAL && can) begin
        pend_q <= 1'b0;
      end
      if (clear_i) begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          col_q[i] <= '0;
          row_q[i] <= '0;
        end
      end else if (upd_cnt) begin
        if ({1'b0, WidthBits'(x)} + 16'd1 >= {1'b0, wl}) begin
          col_q[lv_q] <= '0;
          row_q[lv_q] <= ({1'b0, HeightBits'(y)} + 14'd1 >= {1'b0, hl}) ? '0
                         : y + RowBits'(1);
        end else begin
          col_q[lv_q] <= x + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pix_q <= in_data_i;
    end else if (state_q == S_MERGE) begin
      pix_q <= avg;
    end
    if (state_q == S_EVAL && can && hold_wr) begin
      held_q[lv_q] <= pix_q;
    end
    if (state_q == S_EVAL && can && go) begin
      sum_q <= psum;
      pend_lv_q <= k;
      pend_col_q <= 11'(x >> 1);
      pend_row_q <= 11'(y >> 1);
    end
    if (load_out) begin
      olv_q <= pend_lv_q;
      ocol_q <= pend_col_q;
      orow_q <= pend_row_q;
      opix_q <= pix_q;
      olast_q <= !go;
    end
  end

  assign res_o.valid = ovalid_q;
  assign res_o.level = olv_q;
  assign res_o.column = ocol_q;
  assign res_o.row = orow_q;
  assign res_o.out_red = opix_q.r;
  assign res_o.out_green = opix_q.g;
  assign res_o.out_blue = opix_q.b;
  assign res_o.out_alpha = opix_q.a;
  assign res_o.last = olast_q;

  a_merge_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MERGE |-> $past(state_q) == S_EVAL)
    else $error("merge step without a preceding level evaluation");

  a_pend_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> lv_q != '0)
    else $error("pending result at the base level");

  a_out_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> res_o.level != 4'd0)
    else $error("result item carries level zero");

endmodule
`default_nettype wire

@@ rtl/mipmap_chain_downsampler.sv @@
`default_nettype none
// Box-filter mip chain generator. Base-level RGBA8 pixels enter in raster order and every
// level from 1 to level_count-1 comes out as rounded 2x2 averages in raster order per level,
// the lower level first when one pixel completes blocks on several levels. The input queue
// decouples the pixel port from a level sequencer that evaluates one level per cycle unless the
// result output stalls, and goes through a merge state for the registered read of the pair-sum
// RAM for each result; a pixel causes about a third of a result on average, and the next pixel
// is taken only when the last one is through all its levels.
// The configuration is written between images; a write to the width, height or level register restarts the image.
module mipmap_chain_downsampler import mcd_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_LEVELS = 13
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [12:0] cfg_data_i,
  mcd_pix_if.sink          pix_i,
  mcd_res_if.source        res_o
);

  logic [12:0] width_q;
  logic [12:0] height_q;
  logic [3:0]  levels_q;
  cfg_t        cfg;
  logic        q_valid;
  logic        q_pop;
  pixel_t      q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 13'd4096;
      height_q <= 13'd4096;
      levels_q <= 4'd13;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH: width_q <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_LEVELS: levels_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      cfg.width = WidthBits'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      cfg.width = WidthBits'(MAX_WIDTH);
    end else begin
      cfg.width = WidthBits'(width_q);
    end
    if (height_q == '0) begin
      cfg.height = HeightBits'(1);
    end else if (32'(height_q) > MaxHeight) begin
      cfg.height = HeightBits'(MaxHeight);
    end else begin
      cfg.height = height_q;
    end
    if (levels_q == '0) begin
      cfg.levels = LevelBits'(1);
    end else if (32'(levels_q) > MAX_LEVELS) begin
      cfg.levels = LevelBits'(MAX_LEVELS);
    end else begin
      cfg.levels = levels_q;
    end
  end

  mcd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_i),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  mcd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .clear_i    (cfg_we_i && cfg_idx_i != 2'd3),
    .in_valid_i (q_valid),
    .in_data_i  (q_data),
    .pop_o      (q_pop),
    .res_o      (res_o)
  );

endmodule
`default_nettype wire

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mcd_pkg::*;

  typedef struct {
    logic [3:0]  level;
    logic [10:0] column;
    logic [10:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
  } mip_px_t;

  localparam int NumLevels = 13;
  localparam int RowWords = 4096;
  localparam int CycleLimit = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = 2'd0;
  logic [12:0] cfg_data_i = 13'd0;

  mcd_pix_if pix_if ();
  mcd_res_if res_if ();

  mipmap_chain_downsampler u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pix_i(pix_if.sink), .res_o(res_if.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [31:0] pixel_q[$];
  mip_px_t mip_expect_q[$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int pixels_sent = 0;
  bit idle_ok = 1'b1;
  bit send_hold = 1'b0;
  bit pix_taken = 1'b0;

  logic [12:0] width_reg = 13'd4096;
  logic [12:0] height_reg = 13'd4096;
  logic [3:0] levels_reg = 4'd13;
  logic [8:0] pair_rows[RowWords][4];
  logic [7:0] held[NumLevels][4];
  int col_pos[NumLevels];
  int row_pos[NumLevels];

  function automatic int sat(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic reset_positions();
    for (int i = 0; i < NumLevels; i++) begin
      col_pos[i] = 0;
      row_pos[i] = 0;
    end
  endtask

  task automatic predict_mips(input logic [31:0] p);
    int w0, h0, nlev, wl, hl, x, y, k, wn, hn, idx, n;
    logic [7:0] px[4];
    logic [8:0] s[4];
    mip_px_t e;
    w0 = sat(width_reg, 4096);
    h0 = sat(height_reg, 4096);
    nlev = sat(levels_reg, NumLevels);
    n = 0;
    for (int c = 0; c < 4; c++) px[c] = p[31 - 8 * c -: 8];
    for (int lv = 0; lv < nlev; lv++) begin
      wl = w0 >> lv;
      hl = h0 >> lv;
      x = col_pos[lv];
      y = row_pos[lv];
      k = lv + 1;
      if (wl == 0 || hl == 0) break;
      if (x + 1 >= wl) begin
        col_pos[lv] = 0;
        row_pos[lv] = (y + 1 >= hl) ? 0 : y + 1;
      end else begin
        col_pos[lv] = x + 1;
      end
      if (k >= nlev) break;
      wn = w0 >> k;
      hn = h0 >> k;
      if (wn == 0 || hn == 0) break;
      if (x >= 2 * wn || y >= 2 * hn) break;
      if (x % 2 == 0) begin
        for (int c = 0; c < 4; c++) held[lv][c] = px[c];
        break;
      end
      for (int c = 0; c < 4; c++) s[c] = held[lv][c] + px[c];
      idx = RowWords - (RowWords >> lv) + (x >> 1);
      if (idx >= RowWords) break;
      if (y % 2 == 0) begin
        for (int c = 0; c < 4; c++) pair_rows[idx][c] = s[c];
        break;
      end
      for (int c = 0; c < 4; c++) px[c] = 8'((10'(pair_rows[idx][c]) + s[c] + 10'd2) >> 2);
      e.level = 4'(k);
      e.column = 11'(x >> 1);
      e.row = 11'(y >> 1);
      e.red = px[0];
      e.green = px[1];
      e.blue = px[2];
      e.alpha = px[3];
      e.last = 1'b0;
      mip_expect_q.push_back(e);
      n++;
    end
    if (n > 0) mip_expect_q[$].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Driver: takes the next pending item and holds it until accepted, and drives result ready.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!pix_if.valid || pix_taken) begin
        if (pixel_q.size() > 0 && !send_hold && (idle_ok || $urandom_range(99) >= 9)) begin
          pix_if.valid <= 1'b1;
          {pix_if.red, pix_if.green, pix_if.blue, pix_if.alpha} <= pixel_q[0];
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
      pix_taken = 1'b0;
      res_if.ready <= idle_ok || $urandom_range(99) >= 9;
    end
  end

  initial begin
    pix_if.valid = 1'b0;
    {pix_if.red, pix_if.green, pix_if.blue, pix_if.alpha} = '0;
    res_if.ready = 1'b0;
  end

  // Monitor: predicts on accepted pixels and checks accepted results.
  always @(posedge clk_i) begin
    mip_px_t e;
    if (rst_ni) begin
      cycles++;
      if (pix_if.valid && pix_if.ready) begin
        predict_mips({pix_if.red, pix_if.green, pix_if.blue, pix_if.alpha});
        pixel_q.pop_front();
        pixels_sent++;
        pix_taken = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (mip_expect_q.size() == 0) begin
          report_mismatch("unexpected result, level", res_if.level, 0);
        end else begin
          e = mip_expect_q.pop_front();
          if (res_if.level !== e.level) report_mismatch("level", res_if.level, e.level);
          if (res_if.column !== e.column) report_mismatch("column", res_if.column, e.column);
          if (res_if.row !== e.row) report_mismatch("row", res_if.row, e.row);
          if (res_if.out_red !== e.red) report_mismatch("red", res_if.out_red, e.red);
          if (res_if.out_green !== e.green) report_mismatch("green", res_if.out_green, e.green);
          if (res_if.out_blue !== e.blue) report_mismatch("blue", res_if.out_blue, e.blue);
          if (res_if.out_alpha !== e.alpha) report_mismatch("alpha", res_if.out_alpha, e.alpha);
          if (res_if.last !== e.last) report_mismatch("last", res_if.last, e.last);
        end
      end
      if (cycles > CycleLimit) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pixel_q.size() > 0 || pix_if.valid || mip_expect_q.size() > 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [12:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_WIDTH: width_reg = val;
      CFG_HEIGHT: height_reg = val;
      default: levels_reg = val[3:0];
    endcase
    reset_positions();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_image(input int w, input int h, input int lv);
    write_reg(CFG_WIDTH, 13'(w));
    write_reg(CFG_HEIGHT, 13'(h));
    write_reg(CFG_LEVELS, 13'(lv));
  endtask

  task automatic queue_image(input int n, input int mode);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: pixel_q.push_back($urandom());
        1: pixel_q.push_back(32'hFFFF_FFFF);
        2: pixel_q.push_back(32'h0);
        default: pixel_q.push_back((i % 2) ? 32'hFFFF_FFFF : 32'h0);
      endcase
    end
  endtask

  initial begin
    int w, h;
    reset_positions();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // Directed part: saturation of zero and oversized registers, odd sizes, extremes.
    set_image(0, 0, 0);
    queue_image(2, 1);
    wait_drained();
    set_image(4, 4, 15);
    queue_image(16, 1);
    queue_image(4, 3);
    wait_drained();
    set_image(5, 3, 3);
    queue_image(15, 2);
    wait_drained();
    set_image(8191, 2, 2);
    queue_image(8, 0);
    repeat (3) @(negedge clk_i);
    send_hold = 1'b1;
    while (pix_if.valid || mip_expect_q.size() > 0) @(negedge clk_i);
    send_hold = 1'b0;
    wait_drained();
    // Random part: small images over several settings, some sent twice to wrap to a second image.
    idle_ok = 1'b0;
    for (int img = 0; img < 12; img++) begin
      if (img == 6) idle_ok = 1'b1;
      if (img == 9) idle_ok = 1'b0;
      w = (img % 5 == 0) ? $urandom_range(8, 16) : $urandom_range(1, 9);
      h = $urandom_range(1, 6);
      set_image(w, h, $urandom_range(0, 15));
      queue_image(w * h + ((img % 6 == 0) ? w * h : 0), 0);
      if (img % 3 == 0) queue_image($urandom_range(1, 5), 0);
      wait_drained();
    end
    $display("Sent %0d pixels and checked %0d mip results across many image settings.",
             pixels_sent, results_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mcd_pkg.sv
rtl/mcd_pix_if.sv
rtl/mcd_res_if.sv
rtl/mcd_ram.sv
rtl/mcd_front.sv
rtl/mcd_back.sv
rtl/mipmap_chain_downsampler.sv
sim/tb.sv
